### hdl/cubic_joint_trajectory_assert.svh
// Assertion macros used by the cubic joint trajectory back end.
`ifndef CUBIC_JOINT_TRAJECTORY_ASSERT_SVH
`define CUBIC_JOINT_TRAJECTORY_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define CJT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cubic joint trajectory assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define CJT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cubic joint trajectory assertion failed");
`else
`define CJT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CJT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/cjt_pkg.sv
// Types and constants shared by the cubic joint trajectory modules.
package cjt_pkg;

    // Default build values.
    localparam int CJT_JOINTS    = 16;
    localparam int CJT_FRAC_BITS = 16;

    // At most this many results per tick, as the joint field is four bits wide.
    localparam int MAX_OUT = 16;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_MOVE_DURATION = 32'd1;
    localparam logic [31:0] RST_START_TIME    = 32'd0;
    localparam logic [4:0]  RST_JOINT_COUNT   = 5'd6;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        REG_MOVE_DURATION = 2'd0,
        REG_START_TIME    = 2'd1,
        REG_JOINT_COUNT   = 2'd2
    } t_reg_idx;

    // Where a tick falls relative to the motion window.
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_GOAL   = 2'd1,
        MODE_INTERP = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_DIV  = 3'd1,
        ST_SQR  = 3'd2,
        ST_CUBE = 3'd3,
        ST_WALK = 3'd4
    } t_state;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] move_duration;
        logic [31:0] start_time;
        logic [4:0]  joint_count;
    } t_cfg;

    // Classified command as it travels through the queue.
    typedef struct packed {
        t_opcode            op;
        logic [3:0]         idx;
        logic signed [31:0] init_pos;
        logic signed [31:0] goal_pos;
        t_mode              mode;
        logic [31:0]        elapsed;
    } t_cmd;

endpackage

### hdl/cjt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cjt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = cjt_pkg::CJT_JOINTS,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cjt_front.sv
// Front end: accepts input beats and classifies ticks against the motion window.
module cjt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cjt_pkg::t_cfg        i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [3:0]           i_joint_index,
    input  logic signed [31:0]   i_init_pos,
    input  logic signed [31:0]   i_goal_pos,
    input  logic [31:0]          i_current_time,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output cjt_pkg::t_cmd        o_push_data
);

    logic          r_valid;
    cjt_pkg::t_cmd r_cmd;
    cjt_pkg::t_cmd n_cmd;
    logic [32:0]   end_time;
    logic          accept;

    // Classify the time: at or before start, at or after end, or in between.
    always_comb begin
        end_time      = {1'b0, i_cfg.start_time} + {1'b0, i_cfg.move_duration};
        n_cmd.op       = cjt_pkg::t_opcode'(i_opcode);
        n_cmd.idx      = i_joint_index;
        n_cmd.init_pos = i_init_pos;
        n_cmd.goal_pos = i_goal_pos;
        n_cmd.elapsed  = i_current_time - i_cfg.start_time;
        if (i_current_time <= i_cfg.start_time) begin
            n_cmd.mode = cjt_pkg::MODE_START;
        end else if ({1'b0, i_current_time} >= end_time) begin
            n_cmd.mode = cjt_pkg::MODE_GOAL;
        end else begin
            n_cmd.mode = cjt_pkg::MODE_INTERP;
        end
    end

    assign o_in_ready = !r_valid || i_push_ready;
    assign accept     = i_in_valid && o_in_ready;

    // One holding register in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_cmd;

endmodule

### hdl/cjt_queue.sv
// Short command queue that decouples the front end from the back end.
module cjt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  cjt_pkg::t_cmd i_push_data,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output cjt_pkg::t_cmd o_pop_data
);

    cjt_pkg::t_cmd                    r_mem [cjt_pkg::QUEUE_DEPTH];
    logic [cjt_pkg::QUEUE_PW-1:0]     r_wptr;
    logic [cjt_pkg::QUEUE_PW-1:0]     r_rptr;
    logic [cjt_pkg::QUEUE_CW-1:0]     r_count;
    logic                             push;
    logic                             pop;

    assign o_push_ready = (r_count != cjt_pkg::QUEUE_CW'(cjt_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rptr];

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == cjt_pkg::QUEUE_PW'(cjt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == cjt_pkg::QUEUE_PW'(cjt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

### hdl/cjt_back.sv
// Back end: serial divide, blend weight, and per-joint interpolation pipeline.
`include "cubic_joint_trajectory_assert.svh"
module cjt_back #(
    parameter int JOINTS    = cjt_pkg::CJT_JOINTS,
    parameter int FRAC_BITS = cjt_pkg::CJT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cjt_pkg::t_cfg        i_cfg,
    input  logic                 i_cmd_valid,
    input  cjt_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [3:0]           o_out_joint,
    output logic signed [31:0]   o_position,
    output logic                 o_last
);

    localparam int AW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int SW    = $clog2(FRAC_BITS + 1);
    localparam int PB    = FRAC_BITS + 35;
    localparam int LIMIT = (JOINTS < cjt_pkg::MAX_OUT) ? JOINTS : cjt_pkg::MAX_OUT;

    cjt_pkg::t_state         r_state, n_state;
    logic [31:0]             r_rem, n_rem;
    logic [FRAC_BITS-1:0]    r_quo, n_quo;
    logic [FRAC_BITS-1:0]    r_q, n_q;
    logic [FRAC_BITS:0]      r_h, n_h;
    logic [SW-1:0]           r_step, n_step;
    logic [4:0]              r_jnt, n_jnt;

    logic [4:0]              joint_lim;
    logic                    advance;
    logic                    issue;
    logic                    last_issue;
    logic                    ram_we;
    logic [32:0]             rem_dbl;
    logic [2*FRAC_BITS-1:0]  sq;
    logic [FRAC_BITS+1:0]    wgt;
    logic [2*FRAC_BITS+1:0]  cube;

    logic [63:0]             ram_rdata;
    logic signed [31:0]      rd_start;
    logic signed [31:0]      rd_goal;
    logic signed [32:0]      diff;
    logic signed [FRAC_BITS+1:0] h_signed;
    logic signed [PB-1:0]    prod;
    logic signed [PB-1:0]    blend_sum;

    logic                    r_v1, r_last1;
    logic [3:0]              r_jid1;
    logic                    r_v2, r_last2;
    logic [3:0]              r_jid2;
    logic signed [PB-1:0]    r_prod;
    logic signed [31:0]      r_a2;
    logic                    r_vo, r_last_o;
    logic [3:0]              r_jid_o;
    logic signed [31:0]      r_pos;

    // Effective joint count: zero acts as one, clamped to the table size and to MAX_OUT.
    always_comb begin
        if (i_cfg.joint_count == 5'd0) begin
            joint_lim = 5'd1;
        end else if (i_cfg.joint_count > 5'(LIMIT)) begin
            joint_lim = 5'(LIMIT);
        end else begin
            joint_lim = i_cfg.joint_count;
        end
    end

    // Datapath pieces for the divide and the blend weight.
    assign rem_dbl    = {r_rem, 1'b0};
    assign sq         = r_quo * r_quo;
    assign wgt        = {2'b11, {FRAC_BITS{1'b0}}} - {1'b0, r_quo, 1'b0};
    assign cube       = r_q * wgt;
    assign advance    = !r_vo || i_out_ready;
    assign last_issue = ((r_jnt + 5'd1) == joint_lim);

    // Sequencer: next state and control.
    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_q       = r_q;
        n_h       = r_h;
        n_step    = r_step;
        n_jnt     = r_jnt;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        issue     = 1'b0;
        case (r_state)
            cjt_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == cjt_pkg::OP_LOAD) begin
                        o_cmd_pop = 1'b1;
                        ram_we    = (int'(i_cmd.idx) < JOINTS);
                    end else if (!r_v1 && !r_v2) begin
                        // A tick waits until no beat of the previous walk is ahead of the output register.
                        o_cmd_pop = 1'b1;
                        n_jnt     = '0;
                        case (i_cmd.mode)
                            cjt_pkg::MODE_START: begin
                                n_h     = '0;
                                n_state = cjt_pkg::ST_WALK;
                            end
                            cjt_pkg::MODE_GOAL: begin
                                n_h     = {1'b1, {FRAC_BITS{1'b0}}};
                                n_state = cjt_pkg::ST_WALK;
                            end
                            default: begin
                                n_rem   = i_cmd.elapsed;
                                n_quo   = '0;
                                n_step  = '0;
                                n_state = cjt_pkg::ST_DIV;
                            end
                        endcase
                    end
                end
            end
            cjt_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (rem_dbl >= {1'b0, i_cfg.move_duration}) begin
                    n_rem = 32'(rem_dbl - {1'b0, i_cfg.move_duration});
                    n_quo = {r_quo[FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_rem = rem_dbl[31:0];
                    n_quo = {r_quo[FRAC_BITS-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == SW'(FRAC_BITS - 1)) begin
                    n_state = cjt_pkg::ST_SQR;
                end
            end
            cjt_pkg::ST_SQR: begin
                n_q     = sq[2*FRAC_BITS-1:FRAC_BITS];
                n_state = cjt_pkg::ST_CUBE;
            end
            cjt_pkg::ST_CUBE: begin
                n_h     = cube[2*FRAC_BITS:FRAC_BITS];
                n_state = cjt_pkg::ST_WALK;
            end
            cjt_pkg::ST_WALK: begin
                if (advance) begin
                    issue = 1'b1;
                    n_jnt = r_jnt + 5'd1;
                    if (last_issue) begin
                        n_state = cjt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = cjt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cjt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer working registers.
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_q    <= n_q;
        r_h    <= n_h;
        r_step <= n_step;
        r_jnt  <= n_jnt;
    end

    // Endpoint table: goal in the upper half, start in the lower half.
    cjt_ram #(
        .WIDTH (64),
        .DEPTH (JOINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.idx)),
        .i_wdata ({i_cmd.goal_pos, i_cmd.init_pos}),
        .i_re    (issue),
        .i_raddr (AW'(r_jnt)),
        .o_rdata (ram_rdata)
    );

    // Blend: start + floor((goal - start) * h / 2^FRAC_BITS).
    assign rd_start  = ram_rdata[31:0];
    assign rd_goal   = ram_rdata[63:32];
    assign diff      = 33'(rd_goal) - 33'(rd_start);
    assign h_signed  = $signed({1'b0, r_h});
    assign prod      = diff * h_signed;
    assign blend_sum = (r_prod >>> FRAC_BITS) + PB'(r_a2);

    // Pipeline valids advance together; the whole pipe stalls on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else if (advance) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_vo <= r_v2;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_last1  <= last_issue;
            r_jid1   <= r_jnt[3:0];
            r_prod   <= prod;
            r_a2     <= rd_start;
            r_last2  <= r_last1;
            r_jid2   <= r_jid1;
            r_pos    <= blend_sum[31:0];
            r_last_o <= r_last2;
            r_jid_o  <= r_jid2;
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_joint = r_jid_o;
    assign o_position  = r_pos;
    assign o_last      = r_last_o;

    // A tick never starts while a beat of the previous walk is ahead of the output register.
    `CJT_ASSERT_IMP(a_tick_pop_drained, i_clk, i_rst_n, o_cmd_pop && (i_cmd.op == cjt_pkg::OP_TICK), !r_v1 && !r_v2)
    // The division remainder stays below the divisor.
    `CJT_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == cjt_pkg::ST_DIV, r_rem < i_cfg.move_duration)
    // The walk never addresses a joint beyond the count.
    `CJT_ASSERT_IMP(a_walk_in_range, i_clk, i_rst_n, r_state == cjt_pkg::ST_WALK, r_jnt < joint_lim)
    // The marked beat carries the final joint.
    `CJT_ASSERT_IMP(a_last_is_final, i_clk, i_rst_n, r_vo && r_last_o, r_jid_o == 4'(joint_lim - 5'd1))
    // Issuing the final joint ends the walk.
    `CJT_ASSERT_NXT(a_walk_ends, i_clk, i_rst_n, issue && last_issue, r_state == cjt_pkg::ST_IDLE)

endmodule

### hdl/cubic_joint_trajectory.sv
// Load beat: goes through the front register and queue into the endpoint table; no result.
// Tick beat: interpolating ticks run the serial divider, then square and cube steps for
// the blend weight; results then follow one per cycle while the output is not stalled.
// Ticks outside the motion window skip the divider and blend weight and walk at once.
// Synchronous active-low reset clears control state and sets the configuration
// registers; endpoint table contents are undefined until loaded.
module cubic_joint_trajectory #(
    parameter int JOINTS    = cjt_pkg::CJT_JOINTS,
    parameter int FRAC_BITS = cjt_pkg::CJT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [3:0]           i_joint_index,
    input  logic signed [31:0]   i_init_pos,
    input  logic signed [31:0]   i_goal_pos,
    input  logic [31:0]          i_current_time,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [3:0]           o_out_joint,
    output logic signed [31:0]   o_position,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [31:0]          i_cfg_data
);

    cjt_pkg::t_cfg r_cfg;
    logic          push_valid;
    logic          push_ready;
    cjt_pkg::t_cmd push_data;
    logic          pop_valid;
    logic          pop;
    cjt_pkg::t_cmd pop_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_duration <= cjt_pkg::RST_MOVE_DURATION;
            r_cfg.start_time    <= cjt_pkg::RST_START_TIME;
            r_cfg.joint_count   <= cjt_pkg::RST_JOINT_COUNT;
        end else if (i_cfg_we) begin
            case (cjt_pkg::t_reg_idx'(i_cfg_addr))
                cjt_pkg::REG_MOVE_DURATION: r_cfg.move_duration <= i_cfg_data;
                cjt_pkg::REG_START_TIME:    r_cfg.start_time    <= i_cfg_data;
                cjt_pkg::REG_JOINT_COUNT:   r_cfg.joint_count   <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Front end.
    cjt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_joint_index  (i_joint_index),
        .i_init_pos     (i_init_pos),
        .i_goal_pos     (i_goal_pos),
        .i_current_time (i_current_time),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_data    (push_data)
    );

    // Command queue.
    cjt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_data)
    );

    // Back end.
    cjt_back #(
        .JOINTS    (JOINTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_data),
        .o_cmd_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_joint (o_out_joint),
        .o_position  (o_position),
        .o_last      (o_last)
    );

endmodule
